### rtl/approx_slerp_normalized_unit_assert.svh
// Assertion macros for the approximate slerp unit.
// Included by rtl/approx_slerp_normalized_unit.sv; expects clk_i and rst_ni in scope.
`ifndef APPROX_SLERP_NORMALIZED_UNIT_ASSERT_SVH
`define APPROX_SLERP_NORMALIZED_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ASNU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("asnu: assertion failed");
`define ASNU_NEVER(lbl, cond) `ASNU_ASSERT(lbl, !(cond))
`else
`define ASNU_ASSERT(lbl, prop)
`define ASNU_NEVER(lbl, cond)
`endif
`endif

### rtl/asnu_pkg.sv
// Package for the approximate slerp unit: word types and fixed-point constants.
// No dependencies; used by rtl/approx_slerp_normalized_unit.sv.
package asnu_pkg;

  // Constants of the blend correction with 16 fraction bits: Q0.16, ONE and HALF in Q1.16
  localparam logic [15:0] ATT_Q16  = 16'd53927;
  localparam logic [15:0] KC_Q16   = 16'd38372;
  localparam logic [16:0] ONE_Q16  = 17'd65536;
  localparam logic [16:0] HALF_Q16 = 17'd32768;

  // Iteration counts of the root and divider pipelines
  localparam int unsigned SQRT_STEPS = 31;
  localparam int unsigned DIV_STEPS  = 17;
  localparam int unsigned LANES      = 4;

  typedef struct packed {
    logic signed [15:0] start_w;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] start_z;
    logic signed [15:0] end_w;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic signed [15:0] end_z;
    logic        [16:0] blend;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] out_w;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic               zero_length;
  } out_word_t;

endpackage

### rtl/approx_slerp_normalized_unit.sv
// Approximate quaternion slerp: corrected linear blend followed by normalisation.
// Depends on rtl/asnu_pkg.sv and rtl/approx_slerp_normalized_unit_assert.svh.

// One word is taken in every clock cycle and its result appears with done_o; busy
// stays low, so start may be held high continuously. The receiver cannot stall the
// unit. Each word passes through the 31-step square-root pipeline and the 17-step
// divider pipeline that follow the dot product, correction and lerp stages.
// A blended quaternion of zero length comes out as zero with zero_length set.
`include "approx_slerp_normalized_unit_assert.svh"

module approx_slerp_normalized_unit
  import asnu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_word_t  item_i,
  output logic      done_o,
  output out_word_t result_o
);

  localparam int unsigned SQ0    = 19;
  localparam int unsigned DV_SET = SQ0 + SQRT_STEPS;
  localparam int unsigned DV0    = DV_SET + 1;
  localparam int unsigned LAST   = DV0 + DIV_STEPS;

  typedef struct packed {
    logic [3:0][24:0] mag;
    logic [3:0]       neg;
    logic [4:0]       e;
    logic             zero;
  } side_t;

  typedef struct packed {
    logic [3:0][47:0] rem;
    logic [3:0][16:0] quo;
    logic [3:0]       neg;
    logic [31:0]      den;
    logic             zero;
  } div_t;

  // ---------------------------------------------------------------- valid pipe
  logic [LAST:1] vld_q, vld_d;

  assign busy  = 1'b0;
  assign vld_d = {vld_q[LAST-1:1], start};

  // advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // ---------------------------------------------------------------- stage 1
  logic signed [15:0] in_a [LANES];
  logic signed [15:0] in_b [LANES];
  logic        [16:0] t_clamp;

  always_comb begin
    in_a[0] = item_i.start_w;
    in_a[1] = item_i.start_x;
    in_a[2] = item_i.start_y;
    in_a[3] = item_i.start_z;
    in_b[0] = item_i.end_w;
    in_b[1] = item_i.end_x;
    in_b[2] = item_i.end_y;
    in_b[3] = item_i.end_z;
    t_clamp = (item_i.blend > ONE_Q16) ? ONE_Q16 : item_i.blend;
  end

  logic signed [31:0] s1_prod_q [LANES];
  logic signed [15:0] opa_q [1:13][LANES];
  logic signed [16:0] opd_q [1:12][LANES];
  logic        [16:0] t_q [1:6];

  // form the dot product terms and lerp differences, hold operands
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < LANES; i++) begin
      s1_prod_q[i] <= in_a[i] * in_b[i];
      opa_q[1][i]  <= in_a[i];
      opd_q[1][i]  <= 17'(in_b[i]) - 17'(in_a[i]);
    end
    t_q[1] <= t_clamp;
    for (int j = 2; j <= 13; j++) begin
      opa_q[j] <= opa_q[j-1];
    end
    for (int j = 2; j <= 12; j++) begin
      opd_q[j] <= opd_q[j-1];
    end
    for (int j = 2; j <= 6; j++) begin
      t_q[j] <= t_q[j-1];
    end
  end

  // ---------------------------------------------------------------- stages 2 to 6
  logic signed [33:0] dot_rnd;
  logic signed [21:0] s2_c_q;
  logic signed [38:0] s3_sc_q;
  logic signed [38:0] sc_rnd;
  logic signed [22:0] att_c;
  logic signed [24:0] s4_f_q;
  logic signed [49:0] ff_full;
  logic        [43:0] s5_ff_q;
  logic        [59:0] s6_fk_q;

  assign dot_rnd = 34'(s1_prod_q[0]) + 34'(s1_prod_q[1]) + 34'(s1_prod_q[2])
                 + 34'(s1_prod_q[3]) + 34'sd2048;
  assign sc_rnd  = s3_sc_q + 39'sd32768;
  assign att_c   = sc_rnd[38:16];
  assign ff_full = s4_f_q * s4_f_q;

  // cosine, attenuation, factor squared and gain product
  always_ff @(posedge clk_i) begin
    s2_c_q  <= dot_rnd[33:12];
    s3_sc_q <= $signed({1'b0, ATT_Q16}) * s2_c_q;
    s4_f_q  <= 25'sd65536 - 25'(att_c);
    s5_ff_q <= ff_full[43:0];
    s6_fk_q <= s5_ff_q * KC_Q16;
  end

  // ---------------------------------------------------------------- stages 7 to 12
  logic [59:0] fk_rnd;
  logic        mir_now;
  logic [16:0] u_full;

  assign fk_rnd  = s6_fk_q + 60'h0_0000_0080_0000_00;
  assign mir_now = t_q[6] > HALF_Q16;
  assign u_full  = mir_now ? (ONE_Q16 - t_q[6]) : t_q[6];

  logic [25:0] k_q   [7:9];
  logic [15:0] u_q   [7:10];
  logic        mir_q [7:11];

  logic        [41:0] s8_kur_q;
  logic        [41:0] kur_rnd;
  logic        [25:0] ku;
  logic signed [18:0] w_term;
  logic signed [45:0] s9_kw_q;
  logic signed [45:0] kw_rnd;
  logic signed [29:0] inner;
  logic signed [31:0] s10_p_q;
  logic signed [48:0] s11_up_q;
  logic signed [48:0] up_rnd;
  logic signed [32:0] bend;
  logic signed [32:0] tp_full;
  logic signed [27:0] s12_tp_q;

  assign kur_rnd = s8_kur_q + 42'd32768;
  assign ku      = kur_rnd[41:16];
  assign w_term  = $signed({2'b00, u_q[8], 1'b0}) - 19'sd196608;
  assign kw_rnd  = s9_kw_q + 46'sd32768;
  assign inner   = kw_rnd[45:16];
  assign up_rnd  = s11_up_q + 49'sd32768;
  assign bend    = up_rnd[48:16];
  assign tp_full = mir_q[11] ? (33'sd65536 - bend) : bend;

  // bend the blend fraction with the cubic correction, mirrored about one half
  always_ff @(posedge clk_i) begin
    k_q[7]   <= fk_rnd[57:32];
    u_q[7]   <= u_full[15:0];
    mir_q[7] <= mir_now;
    k_q[8]   <= k_q[7];
    k_q[9]   <= k_q[8];
    for (int j = 8; j <= 10; j++) begin
      u_q[j] <= u_q[j-1];
    end
    for (int j = 8; j <= 11; j++) begin
      mir_q[j] <= mir_q[j-1];
    end
    s8_kur_q <= k_q[7] * u_q[7];
    s9_kw_q  <= $signed({1'b0, ku}) * w_term;
    s10_p_q  <= 32'(inner) + 32'sd65536 + $signed({6'b0, k_q[9]});
    s11_up_q <= $signed({1'b0, u_q[10]}) * s10_p_q;
    s12_tp_q <= tp_full[27:0];
  end

  // ---------------------------------------------------------------- stages 13 to 18
  logic signed [44:0] s13_lp_q [LANES];
  logic signed [44:0] lp_rnd   [LANES];
  logic signed [28:0] l_full   [LANES];
  logic signed [25:0] s14_l_q  [LANES];
  logic signed [51:0] sq_full  [LANES];
  logic        [49:0] s15_sq_q [LANES];
  logic        [24:0] s15_mag_q [LANES];
  logic        [3:0]  s15_neg_q;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      lp_rnd[i]  = s13_lp_q[i] + 45'sd32768;
      l_full[i]  = 29'(opa_q[13][i]) + $signed(lp_rnd[i][44:16]);
      sq_full[i] = s14_l_q[i] * s14_l_q[i];
    end
  end

  // lerp each component, then take magnitudes and squares
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < LANES; i++) begin
      s13_lp_q[i]  <= s12_tp_q * opd_q[12][i];
      s14_l_q[i]   <= l_full[i][25:0];
      s15_sq_q[i]  <= sq_full[i][49:0];
      s15_mag_q[i] <= s14_l_q[i][25] ? 25'(-s14_l_q[i]) : s14_l_q[i][24:0];
      s15_neg_q[i] <= s14_l_q[i][25];
    end
  end

  function automatic logic [5:0] bit_len(input logic [51:0] v);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 52; i++) begin
      if (v[i]) begin
        n = 6'(i + 1);
      end
    end
    return n;
  endfunction

  logic [51:0] s16_n2_q;
  side_t       s16_side_q;
  logic [51:0] s17_n2_q;
  side_t       s17_side_q;
  logic [61:0] s18_x_q;
  side_t       s18_side_q;
  logic [5:0]  n2_len;
  side_t       side_e;

  assign n2_len = bit_len(s16_n2_q);

  always_comb begin
    side_e      = s16_side_q;
    side_e.e    = 5'((7'd62 - 7'(n2_len)) >> 1);
    side_e.zero = (s16_n2_q == '0);
  end

  // sum the squares, find the even shift and normalise the squared length
  always_ff @(posedge clk_i) begin
    s16_n2_q <= 52'(s15_sq_q[0]) + 52'(s15_sq_q[1]) + 52'(s15_sq_q[2]) + 52'(s15_sq_q[3]);
    for (int i = 0; i < LANES; i++) begin
      s16_side_q.mag[i] <= s15_mag_q[i];
    end
    s16_side_q.neg  <= s15_neg_q;
    s16_side_q.e    <= '0;
    s16_side_q.zero <= 1'b0;
    s17_n2_q        <= s16_n2_q;
    s17_side_q      <= side_e;
    s18_x_q         <= {10'b0, s17_n2_q} << {s17_side_q.e, 1'b0};
    s18_side_q      <= s17_side_q;
  end

  // ---------------------------------------------------------------- square root
  logic [61:0] sq_rem_q  [SQRT_STEPS];
  logic [61:0] sq_res_q  [SQRT_STEPS];
  side_t       sq_side_q [SQRT_STEPS];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [61:0] BIT = 62'(1) << (60 - 2 * j);
    logic [61:0] rem_in, res_in, trial;
    side_t       side_in;

    if (j == 0) begin : g_first
      assign rem_in  = s18_x_q;
      assign res_in  = '0;
      assign side_in = s18_side_q;
    end else begin : g_next
      assign rem_in  = sq_rem_q[j-1];
      assign res_in  = sq_res_q[j-1];
      assign side_in = sq_side_q[j-1];
    end

    assign trial = res_in + BIT;

    // settle one root bit
    always_ff @(posedge clk_i) begin
      if (rem_in >= trial) begin
        sq_rem_q[j] <= rem_in - trial;
        sq_res_q[j] <= (res_in >> 1) + BIT;
      end else begin
        sq_rem_q[j] <= rem_in;
        sq_res_q[j] <= res_in >> 1;
      end
      sq_side_q[j] <= side_in;
    end
  end

  // ---------------------------------------------------------------- divider
  logic [30:0] root;
  div_t        dv_set;
  logic [55:0] mag_sh [LANES];

  assign root = sq_res_q[SQRT_STEPS-1][30:0];

  always_comb begin
    dv_set      = '0;
    dv_set.den  = {root, 1'b0};
    dv_set.neg  = sq_side_q[SQRT_STEPS-1].neg;
    dv_set.zero = sq_side_q[SQRT_STEPS-1].zero;
    for (int i = 0; i < LANES; i++) begin
      mag_sh[i]     = 56'(sq_side_q[SQRT_STEPS-1].mag[i]) << sq_side_q[SQRT_STEPS-1].e;
      dv_set.rem[i] = 48'({mag_sh[i][30:0], 15'b0}) + 48'(root);
    end
  end

  div_t dv_init_q;
  div_t dv_q [DIV_STEPS];

  // set up rounded numerators and the doubled root
  always_ff @(posedge clk_i) begin
    dv_init_q <= dv_set;
  end

  for (genvar m = 0; m < DIV_STEPS; m++) begin : g_div
    localparam int unsigned QB = DIV_STEPS - 1 - m;
    div_t        dv_in;
    div_t        dv_out;
    logic [47:0] sub;

    if (m == 0) begin : g_first
      assign dv_in = dv_init_q;
    end else begin : g_next
      assign dv_in = dv_q[m-1];
    end

    assign sub = 48'(dv_in.den) << QB;

    always_comb begin
      dv_out = dv_in;
      for (int i = 0; i < LANES; i++) begin
        if (dv_in.rem[i] >= sub) begin
          dv_out.rem[i]     = dv_in.rem[i] - sub;
          dv_out.quo[i][QB] = 1'b1;
        end
      end
    end

    // settle one quotient bit in every lane
    always_ff @(posedge clk_i) begin
      dv_q[m] <= dv_out;
    end
  end

  // ---------------------------------------------------------------- output
  div_t               dv_last;
  logic signed [15:0] comp [LANES];
  out_word_t          result_d, result_q;

  assign dv_last = dv_q[DIV_STEPS-1];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      if (dv_last.zero) begin
        comp[i] = '0;
      end else if (!dv_last.neg[i]) begin
        comp[i] = (dv_last.quo[i] > 17'd32767) ? 16'sd32767 : $signed(dv_last.quo[i][15:0]);
      end else begin
        comp[i] = (dv_last.quo[i] > 17'd32768) ? -16'sd32768
                : 16'(18'sd0 - $signed({1'b0, dv_last.quo[i]}));
      end
    end
    result_d.out_w       = comp[0];
    result_d.out_x       = comp[1];
    result_d.out_y       = comp[2];
    result_d.out_z       = comp[3];
    result_d.zero_length = dv_last.zero;
  end

  // restore signs, saturate and hold the result word
  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign result_o = result_q;
  assign done_o   = vld_q[LAST];

  // ---------------------------------------------------------------- checks
  `ASNU_ASSERT(a_zero_word, done_o && result_o.zero_length |-> (result_o.out_w == 16'sd0 && result_o.out_x == 16'sd0 && result_o.out_y == 16'sd0 && result_o.out_z == 16'sd0))
  `ASNU_NEVER(a_norm_shift, vld_q[18] && !s18_side_q.zero && s18_x_q[61:60] == 2'b00)
  `ASNU_ASSERT(a_root_range, vld_q[DV_SET-1] && !sq_side_q[SQRT_STEPS-1].zero |-> (sq_res_q[SQRT_STEPS-1][30] && sq_res_q[SQRT_STEPS-1][61:31] == 31'd0))
  `ASNU_NEVER(a_quo_range, vld_q[LAST-1] && !dv_last.zero && (dv_last.quo[0][16] || dv_last.quo[1][16] || dv_last.quo[2][16] || dv_last.quo[3][16]))

endmodule
